### rtl/hierarchical_2d_transform_macros.svh
// Assertion macros for the hierarchical 2D transform block.
// Used by hierarchical_2d_transform.sv; expects clk and rst_n in scope.
`ifndef HIERARCHICAL_2D_TRANSFORM_MACROS_SVH
`define HIERARCHICAL_2D_TRANSFORM_MACROS_SVH

// same-cycle implication
`define HTX_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HTX_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/htx_pkg.sv
// Shared types, constants and saturation helper for the 2D transform block.
// No dependencies.
package htx_pkg;

    localparam int MAX_ENTITIES_DEF = 1024;
    localparam int FRAC_BITS_DEF    = 16;

    localparam int Q_W    = 32;            // Q word width
    localparam int OPND_W = 33;            // multiplier operand width
    localparam int PROD_W = 2 * OPND_W;    // full product width
    localparam int VAL_W  = 34;            // post-processed product width
    localparam int SUM_W  = 36;            // writeback sum width
    localparam int Q30_SH = 30;

    // sine polynomial coefficients, Q30
    localparam logic signed [OPND_W-1:0] SIN_A = 33'sd1686629713;
    localparam logic signed [OPND_W-1:0] SIN_B = 33'sd688904866;
    localparam logic signed [OPND_W-1:0] SIN_C = 33'sd76016977;

    typedef enum logic [1:0] {
        M_QMUL,     // round to FRAC_BITS, saturate
        M_Q30,      // truncate 30 fraction bits
        M_RAW,      // saturate plain product
        M_ROUND     // round Q30 sine to FRAC_BITS
    } mode_t;

    function automatic logic signed [Q_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] vmax;
        logic signed [PROD_W-1:0] vmin;
        vmax = PROD_W'(64'sh0000_0000_7FFF_FFFF);
        vmin = -vmax - PROD_W'(1);
        if (v > vmax)
        begin
            return 32'sh7FFF_FFFF;
        end
        else if (v < vmin)
        begin
            return 32'sh8000_0000;
        end
        return v[Q_W-1:0];
    endfunction

endpackage

### rtl/hierarchical_2d_transform.sv
// Top level of the hierarchical 2D transform block: control, entity memories.
// Depends on htx_pkg, htx_mac and hierarchical_2d_transform_macros.svh.
//
// Usage:
//  - Input channel item_valid/item_stall carries one entity word: slot, parent
//    flag and slot, scale, pivot, rotation, position, anchor (Q16.16).
//  - Output channel result_valid/result_stall carries the entity's world
//    matrix (m11..m32) tagged with out_index.
//  - APB port holds viewport_width (0x0) and viewport_height (0x4); write
//    them only while the block is idle.
//  - One word in flight. Both slots are reduced modulo MAX_ENTITIES at accept
//    by a reciprocal multiply; a read state fetches the parent entry, then a
//    sequencer runs the shared 33x33 multiplier with an issue phase and a
//    write-back phase per step: 22 steps for a root, 46 for a child. The
//    next word is taken the cycle after the result is loaded.
//  - Parents must be sent before their children. The parent entry is read
//    after the previous word's write-back, so no forwarding is needed.
//  - A stalled result stays in the output register; the block keeps working
//    on the next word and waits at write-back until the register frees.
//  - Reset returns to idle with the viewport at 1920x1080; the memories
//    are not cleared.
`include "hierarchical_2d_transform_macros.svh"

module hierarchical_2d_transform #(
    parameter int MAX_ENTITIES = htx_pkg::MAX_ENTITIES_DEF,
    parameter int FRAC_BITS    = htx_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [9:0]         entity_index,
    input  logic               has_parent,
    input  logic [9:0]         parent_index,
    input  logic signed [31:0] scale_x,
    input  logic signed [31:0] scale_y,
    input  logic signed [31:0] pivot_x,
    input  logic signed [31:0] pivot_y,
    input  logic [15:0]        rotation,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] anchor_x,
    input  logic signed [31:0] anchor_y,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [9:0]         out_index,
    output logic signed [31:0] m11,
    output logic signed [31:0] m12,
    output logic signed [31:0] m21,
    output logic signed [31:0] m22,
    output logic signed [31:0] m31,
    output logic signed [31:0] m32
);
    import htx_pkg::*;

    localparam int IDX_W  = 10;
    localparam int SLOT_W = (MAX_ENTITIES > 1) ? $clog2(MAX_ENTITIES) : 1;
    localparam int MAT_W  = 6 * Q_W;
    localparam int SCL_W  = 2 * Q_W;

    // slot reduction: quotient = (x * RED_MUL) >> RED_SH, exact for 10-bit x
    localparam int RED_SH = IDX_W + SLOT_W;
    localparam int RED_W  = IDX_W + 2;
    localparam int PRD_W  = IDX_W + RED_W;
    localparam int QM_W   = IDX_W + SLOT_W + 1;
    localparam logic [RED_W-1:0] RED_MUL =
        RED_W'(((64'd1 << RED_SH) + 64'(MAX_ENTITIES) - 64'd1) / 64'(MAX_ENTITIES));

    localparam logic signed [VAL_W-1:0] Q_ONE  = VAL_W'(1) << FRAC_BITS;
    localparam logic signed [VAL_W-1:0] Q_HALF = VAL_W'(1) << (FRAC_BITS - 1);

    localparam logic REG_VW = 1'b0;
    localparam logic REG_VH = 1'b1;

    // sequencer steps
    localparam logic [5:0] OP_SX2  = 6'd0;
    localparam logic [5:0] OP_SINN = 6'd1;
    localparam logic [5:0] OP_SMID = 6'd2;
    localparam logic [5:0] OP_SPRD = 6'd3;
    localparam logic [5:0] OP_SRND = 6'd4;
    localparam logic [5:0] OP_CX2  = 6'd5;
    localparam logic [5:0] OP_CINN = 6'd6;
    localparam logic [5:0] OP_CMID = 6'd7;
    localparam logic [5:0] OP_CPRD = 6'd8;
    localparam logic [5:0] OP_CRND = 6'd9;
    localparam logic [5:0] OP_OX   = 6'd10;
    localparam logic [5:0] OP_OY   = 6'd11;
    localparam logic [5:0] OP_PX   = 6'd12;
    localparam logic [5:0] OP_PY   = 6'd13;
    localparam logic [5:0] OP_L0   = 6'd14;
    localparam logic [5:0] OP_L1   = 6'd15;
    localparam logic [5:0] OP_L2   = 6'd16;
    localparam logic [5:0] OP_L3   = 6'd17;
    localparam logic [5:0] OP_L4A  = 6'd18;
    localparam logic [5:0] OP_L4B  = 6'd19;
    localparam logic [5:0] OP_L5A  = 6'd20;
    localparam logic [5:0] OP_L5B  = 6'd21;
    localparam logic [5:0] OP_W0A  = 6'd22;
    localparam logic [5:0] OP_W0B  = 6'd23;
    localparam logic [5:0] OP_W1A  = 6'd24;
    localparam logic [5:0] OP_W1B  = 6'd25;
    localparam logic [5:0] OP_W2A  = 6'd26;
    localparam logic [5:0] OP_W2B  = 6'd27;
    localparam logic [5:0] OP_W3A  = 6'd28;
    localparam logic [5:0] OP_W3B  = 6'd29;
    localparam logic [5:0] OP_W4A  = 6'd30;
    localparam logic [5:0] OP_W4B  = 6'd31;
    localparam logic [5:0] OP_W5A  = 6'd32;
    localparam logic [5:0] OP_W5B  = 6'd33;
    localparam logic [5:0] OP_T0A  = 6'd34;
    localparam logic [5:0] OP_T0B  = 6'd35;
    localparam logic [5:0] OP_T1A  = 6'd36;
    localparam logic [5:0] OP_T1B  = 6'd37;
    localparam logic [5:0] OP_T2A  = 6'd38;
    localparam logic [5:0] OP_T2B  = 6'd39;
    localparam logic [5:0] OP_T3A  = 6'd40;
    localparam logic [5:0] OP_T3B  = 6'd41;
    localparam logic [5:0] OP_T4A  = 6'd42;
    localparam logic [5:0] OP_T4B  = 6'd43;
    localparam logic [5:0] OP_T5A  = 6'd44;
    localparam logic [5:0] OP_T5B  = 6'd45;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_RUN,
        S_DONE
    } state_t;

    typedef logic signed [Q_W-1:0] q_t;

    // x mod MAX_ENTITIES via reciprocal multiply
    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] x);
        logic [PRD_W-1:0] prod;
        logic [IDX_W-1:0] quo;
        logic [QM_W-1:0]  qm;
        prod = PRD_W'(x) * PRD_W'(RED_MUL);
        quo  = IDX_W'(prod >> RED_SH);
        qm   = QM_W'(quo) * QM_W'(MAX_ENTITIES);
        return x - qm[IDX_W-1:0];
    endfunction

    // ---------------- configuration registers ----------------
    logic [15:0] vw_reg;
    logic [15:0] vh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vw_reg <= 16'd1920;
            vh_reg <= 16'd1080;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[2])
                REG_VW:  vw_reg <= pwdata[15:0];
                REG_VH:  vh_reg <= pwdata[15:0];
                default: vw_reg <= vw_reg;
            endcase
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_VH) ? {16'd0, vh_reg} : {16'd0, vw_reg};

    // ---------------- control state ----------------
    state_t             state_reg;
    logic [5:0]         op_reg;
    logic               phase_reg;
    logic [IDX_W-1:0]   erem_reg;     // entity slot, reduced at accept
    logic [IDX_W-1:0]   prem_reg;     // parent slot, reduced at accept
    logic               result_valid_reg;
    logic [IDX_W-1:0]   out_index_reg;
    q_t                 out_m_reg [6];

    // ---------------- datapath registers ----------------
    logic               has_parent_reg;
    logic [IDX_W-1:0]   idx_reg;
    q_t                 sx_reg, sy_reg, pxs_reg, pys_reg, posx_reg, ahx_reg, ahy_reg;
    logic signed [OPND_W-1:0] nposy_reg;
    q_t                 xs_reg, xc_reg;
    logic               sneg_reg, cneg_reg;
    q_t                 x2_reg, inner_reg, mid_reg, sraw_reg;
    q_t                 sin_reg, cos_reg, ox_reg, oy_reg, px_reg, py_reg;
    q_t                 l_reg [6];
    q_t                 w_reg [6];
    q_t                 t_reg [6];
    logic signed [SUM_W-1:0] acc_reg;

    // ---------------- memories ----------------
    logic [MAT_W-1:0] mat_mem [MAX_ENTITIES];
    logic [SCL_W-1:0] scl_mem [MAX_ENTITIES];
    logic [MAT_W-1:0] mat_rd_reg;
    logic [SCL_W-1:0] scl_rd_reg;

    logic              accept;
    logic              done_fire;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] pslot;
    logic [5:0]        op_last;
    q_t                par [6];
    q_t                psx, psy;
    logic signed [OPND_W-1:0] mul_a, mul_b;
    mode_t             mul_mode;
    logic              wb_neg, wb_acc;
    logic signed [VAL_W-1:0] wb_add, mac_val, wb_val;
    logic signed [SUM_W-1:0] wb_sum;
    q_t                wb_q;
    logic [MAT_W-1:0]  mat_wdata;

    // input preparation
    logic [15:0]       rot_c;
    logic [14:0]       us, uc;
    logic signed [VAL_W-1:0] pxs_w, pys_w, ahx_w, ahy_w;

    assign accept     = item_valid && !item_stall;
    assign item_stall = (state_reg != S_IDLE);
    assign done_fire  = (state_reg == S_DONE) && !(result_valid_reg && result_stall);
    assign slot       = SLOT_W'(erem_reg);
    assign pslot      = SLOT_W'(prem_reg);
    assign op_last    = has_parent_reg ? OP_T5B : OP_L5B;

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            par[i] = mat_rd_reg[Q_W*i +: Q_W];
        end
    end
    assign psx = scl_rd_reg[Q_W-1:0];
    assign psy = scl_rd_reg[SCL_W-1:Q_W];

    always_comb
    begin
        rot_c = rotation + 16'd16384;
        us    = rotation[14] ? (15'd16384 - {1'b0, rotation[13:0]}) : {1'b0, rotation[13:0]};
        uc    = rot_c[14] ? (15'd16384 - {1'b0, rot_c[13:0]}) : {1'b0, rot_c[13:0]};
        pxs_w = Q_ONE - (VAL_W'(pivot_x) <<< 1);
        pys_w = (VAL_W'(pivot_y) <<< 1) - Q_ONE;
        ahx_w = VAL_W'(anchor_x) - Q_HALF;
        ahy_w = Q_HALF - VAL_W'(anchor_y);
    end

    // ---------------- sequencer operand select ----------------
    always_comb
    begin
        mul_a    = '0;
        mul_b    = '0;
        mul_mode = M_QMUL;
        wb_neg   = 1'b0;
        wb_acc   = 1'b0;
        wb_add   = '0;
        case (op_reg)
            OP_SX2:
            begin
                mul_a = OPND_W'(xs_reg); mul_b = OPND_W'(xs_reg); mul_mode = M_Q30;
            end
            OP_SINN, OP_CINN:
            begin
                mul_a = SIN_C; mul_b = OPND_W'(x2_reg); mul_mode = M_Q30;
                wb_neg = 1'b1; wb_add = VAL_W'(SIN_B);
            end
            OP_SMID, OP_CMID:
            begin
                mul_a = OPND_W'(x2_reg); mul_b = OPND_W'(inner_reg); mul_mode = M_Q30;
                wb_neg = 1'b1; wb_add = VAL_W'(SIN_A);
            end
            OP_SPRD:
            begin
                mul_a = OPND_W'(xs_reg); mul_b = OPND_W'(mid_reg); mul_mode = M_Q30;
            end
            OP_SRND:
            begin
                mul_a = OPND_W'(sraw_reg); mul_mode = M_ROUND; wb_neg = sneg_reg;
            end
            OP_CX2:
            begin
                mul_a = OPND_W'(xc_reg); mul_b = OPND_W'(xc_reg); mul_mode = M_Q30;
            end
            OP_CPRD:
            begin
                mul_a = OPND_W'(xc_reg); mul_b = OPND_W'(mid_reg); mul_mode = M_Q30;
            end
            OP_CRND:
            begin
                mul_a = OPND_W'(sraw_reg); mul_mode = M_ROUND; wb_neg = cneg_reg;
            end
            OP_OX:
            begin
                // child: scaled by parent scale; root: by viewport pixels
                mul_a    = OPND_W'(ahx_reg);
                mul_b    = has_parent_reg ? OPND_W'(psx) : $signed({17'd0, vw_reg});
                mul_mode = has_parent_reg ? M_QMUL : M_RAW;
                wb_add   = VAL_W'(posx_reg);
            end
            OP_OY:
            begin
                mul_a    = OPND_W'(ahy_reg);
                mul_b    = has_parent_reg ? OPND_W'(psy) : $signed({17'd0, vh_reg});
                mul_mode = has_parent_reg ? M_QMUL : M_RAW;
                wb_add   = VAL_W'(nposy_reg);
            end
            OP_PX:  begin mul_a = OPND_W'(pxs_reg); mul_b = OPND_W'(sx_reg);  end
            OP_PY:  begin mul_a = OPND_W'(pys_reg); mul_b = OPND_W'(sy_reg);  end
            OP_L0:  begin mul_a = OPND_W'(sx_reg);  mul_b = OPND_W'(cos_reg); end
            OP_L1:  begin mul_a = OPND_W'(sx_reg);  mul_b = OPND_W'(sin_reg); end
            OP_L2:  begin mul_a = OPND_W'(sy_reg);  mul_b = -OPND_W'(sin_reg); end
            OP_L3:  begin mul_a = OPND_W'(sy_reg);  mul_b = OPND_W'(cos_reg); end
            OP_L4A: begin mul_a = OPND_W'(px_reg);  mul_b = OPND_W'(cos_reg); end
            OP_L4B:
            begin
                mul_a = OPND_W'(py_reg); mul_b = -OPND_W'(sin_reg);
                wb_acc = 1'b1; wb_add = VAL_W'(ox_reg);
            end
            OP_L5A: begin mul_a = OPND_W'(px_reg);  mul_b = OPND_W'(sin_reg); end
            OP_L5B:
            begin
                mul_a = OPND_W'(py_reg); mul_b = OPND_W'(cos_reg);
                wb_acc = 1'b1; wb_add = VAL_W'(oy_reg);
            end
            // world = local * parent
            OP_W0A: begin mul_a = OPND_W'(l_reg[0]); mul_b = OPND_W'(par[0]); end
            OP_W0B: begin mul_a = OPND_W'(l_reg[1]); mul_b = OPND_W'(par[2]); wb_acc = 1'b1; end
            OP_W1A: begin mul_a = OPND_W'(l_reg[0]); mul_b = OPND_W'(par[1]); end
            OP_W1B: begin mul_a = OPND_W'(l_reg[1]); mul_b = OPND_W'(par[3]); wb_acc = 1'b1; end
            OP_W2A: begin mul_a = OPND_W'(l_reg[2]); mul_b = OPND_W'(par[0]); end
            OP_W2B: begin mul_a = OPND_W'(l_reg[3]); mul_b = OPND_W'(par[2]); wb_acc = 1'b1; end
            OP_W3A: begin mul_a = OPND_W'(l_reg[2]); mul_b = OPND_W'(par[1]); end
            OP_W3B: begin mul_a = OPND_W'(l_reg[3]); mul_b = OPND_W'(par[3]); wb_acc = 1'b1; end
            OP_W4A: begin mul_a = OPND_W'(l_reg[4]); mul_b = OPND_W'(par[0]); end
            OP_W4B:
            begin
                mul_a = OPND_W'(l_reg[5]); mul_b = OPND_W'(par[2]);
                wb_acc = 1'b1; wb_add = VAL_W'(par[4]);
            end
            OP_W5A: begin mul_a = OPND_W'(l_reg[4]); mul_b = OPND_W'(par[1]); end
            OP_W5B:
            begin
                mul_a = OPND_W'(l_reg[5]); mul_b = OPND_W'(par[3]);
                wb_acc = 1'b1; wb_add = VAL_W'(par[5]);
            end
            // to-child = own * parent
            OP_T0A: begin mul_a = OPND_W'(cos_reg);  mul_b = OPND_W'(par[0]); end
            OP_T0B: begin mul_a = OPND_W'(sin_reg);  mul_b = OPND_W'(par[2]); wb_acc = 1'b1; end
            OP_T1A: begin mul_a = OPND_W'(cos_reg);  mul_b = OPND_W'(par[1]); end
            OP_T1B: begin mul_a = OPND_W'(sin_reg);  mul_b = OPND_W'(par[3]); wb_acc = 1'b1; end
            OP_T2A: begin mul_a = -OPND_W'(sin_reg); mul_b = OPND_W'(par[0]); end
            OP_T2B: begin mul_a = OPND_W'(cos_reg);  mul_b = OPND_W'(par[2]); wb_acc = 1'b1; end
            OP_T3A: begin mul_a = -OPND_W'(sin_reg); mul_b = OPND_W'(par[1]); end
            OP_T3B: begin mul_a = OPND_W'(cos_reg);  mul_b = OPND_W'(par[3]); wb_acc = 1'b1; end
            OP_T4A: begin mul_a = OPND_W'(ox_reg);   mul_b = OPND_W'(par[0]); end
            OP_T4B:
            begin
                mul_a = OPND_W'(oy_reg); mul_b = OPND_W'(par[2]);
                wb_acc = 1'b1; wb_add = VAL_W'(par[4]);
            end
            OP_T5A: begin mul_a = OPND_W'(ox_reg);   mul_b = OPND_W'(par[1]); end
            OP_T5B:
            begin
                mul_a = OPND_W'(oy_reg); mul_b = OPND_W'(par[3]);
                wb_acc = 1'b1; wb_add = VAL_W'(par[5]);
            end
            default: mul_mode = M_QMUL;
        endcase
    end

    htx_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .clk   (clk),
        .issue (state_reg == S_RUN && !phase_reg),
        .a     (mul_a),
        .b     (mul_b),
        .mode  (mul_mode),
        .val   (mac_val)
    );

    // sums are exact, saturated once at the destination
    always_comb
    begin
        wb_val = wb_neg ? -mac_val : mac_val;
        wb_sum = SUM_W'(wb_val) + SUM_W'(wb_add) + (wb_acc ? acc_reg : SUM_W'(0));
        wb_q   = sat32(PROD_W'(wb_sum));
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            has_parent_reg <= has_parent;
            idx_reg        <= entity_index;
            sx_reg         <= scale_x;
            sy_reg         <= scale_y;
            posx_reg       <= pos_x;
            nposy_reg      <= -OPND_W'(pos_y);
            pxs_reg        <= sat32(PROD_W'(pxs_w));
            pys_reg        <= sat32(PROD_W'(pys_w));
            ahx_reg        <= sat32(PROD_W'(ahx_w));
            ahy_reg        <= sat32(PROD_W'(ahy_w));
            xs_reg         <= q_t'({1'b0, us, 16'd0});
            xc_reg         <= q_t'({1'b0, uc, 16'd0});
            sneg_reg       <= rotation[15];
            cneg_reg       <= rot_c[15];
        end
        if (state_reg == S_RUN && phase_reg)
        begin
            acc_reg <= wb_sum;
            case (op_reg)
                OP_SX2, OP_CX2:   x2_reg    <= wb_q;
                OP_SINN, OP_CINN: inner_reg <= wb_q;
                OP_SMID, OP_CMID: mid_reg   <= wb_q;
                OP_SPRD, OP_CPRD: sraw_reg  <= wb_q;
                OP_SRND:          sin_reg   <= wb_q;
                OP_CRND:          cos_reg   <= wb_q;
                OP_OX:            ox_reg    <= wb_q;
                OP_OY:            oy_reg    <= wb_q;
                OP_PX:            px_reg    <= wb_q;
                OP_PY:            py_reg    <= wb_q;
                OP_L0:            l_reg[0]  <= wb_q;
                OP_L1:            l_reg[1]  <= wb_q;
                OP_L2:            l_reg[2]  <= wb_q;
                OP_L3:            l_reg[3]  <= wb_q;
                OP_L4B:           l_reg[4]  <= wb_q;
                OP_L5B:           l_reg[5]  <= wb_q;
                OP_W0B:           w_reg[0]  <= wb_q;
                OP_W1B:           w_reg[1]  <= wb_q;
                OP_W2B:           w_reg[2]  <= wb_q;
                OP_W3B:           w_reg[3]  <= wb_q;
                OP_W4B:           w_reg[4]  <= wb_q;
                OP_W5B:           w_reg[5]  <= wb_q;
                OP_T0B:           t_reg[0]  <= wb_q;
                OP_T1B:           t_reg[1]  <= wb_q;
                OP_T2B:           t_reg[2]  <= wb_q;
                OP_T3B:           t_reg[3]  <= wb_q;
                OP_T4B:           t_reg[4]  <= wb_q;
                OP_T5B:           t_reg[5]  <= wb_q;
                default: ;
            endcase
        end
    end

    // ---------------- memories ----------------
    // root stores its own matrix (c, s, -s, c, ox, oy)
    assign mat_wdata = has_parent_reg
        ? {t_reg[5], t_reg[4], t_reg[3], t_reg[2], t_reg[1], t_reg[0]}
        : {oy_reg, ox_reg, cos_reg, q_t'(-sin_reg), sin_reg, cos_reg};

    always_ff @(posedge clk)
    begin
        if (done_fire)
        begin
            mat_mem[slot] <= mat_wdata;
            scl_mem[slot] <= {sy_reg, sx_reg};
        end
        if (state_reg == S_RD)
        begin
            mat_rd_reg <= mat_mem[pslot];
            scl_rd_reg <= scl_mem[pslot];
        end
    end

    // ---------------- state machine and result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            op_reg           <= OP_SX2;
            phase_reg        <= 1'b0;
            erem_reg         <= '0;
            prem_reg         <= '0;
            result_valid_reg <= 1'b0;
            out_index_reg    <= '0;
            for (int i = 0; i < 6; i++)
            begin
                out_m_reg[i] <= '0;
            end
        end
        else
        begin
            // load wins over drain; both can happen in one cycle
            if (done_fire)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (item_valid)
                    begin
                        erem_reg  <= slot_of(entity_index);
                        prem_reg  <= slot_of(parent_index);
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    op_reg    <= OP_SX2;
                    phase_reg <= 1'b0;
                    state_reg <= S_RUN;
                end
                S_RUN:
                begin
                    phase_reg <= !phase_reg;
                    if (phase_reg)
                    begin
                        if (op_reg == op_last)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            op_reg <= op_reg + 1'b1;
                        end
                    end
                end
                S_DONE:
                begin
                    if (done_fire)
                    begin
                        out_index_reg    <= idx_reg;
                        for (int i = 0; i < 6; i++)
                        begin
                            out_m_reg[i] <= has_parent_reg ? w_reg[i] : l_reg[i];
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign out_index    = out_index_reg;
    assign m11          = out_m_reg[0];
    assign m12          = out_m_reg[1];
    assign m21          = out_m_reg[2];
    assign m22          = out_m_reg[3];
    assign m31          = out_m_reg[4];
    assign m32          = out_m_reg[5];

    // ---------------- assertions ----------------
    `HTX_ASSERT_NXT(a_accept_starts, accept, state_reg == S_RD, "accepted word did not start parent read")
    `HTX_ASSERT_NXT(a_writeback_shows, done_fire, result_valid_reg, "memory write-back without result")
    `HTX_ASSERT_IMP(a_op_bound, state_reg == S_RUN, op_reg <= OP_T5B, "sequencer step out of range")
    `HTX_ASSERT_IMP(a_root_short, state_reg == S_RUN && !has_parent_reg, op_reg <= OP_L5B, "root ran compose steps")

endmodule

### rtl/htx_mac.sv
// Shared multiplier with registered product and Q-format post-processing.
// Depends on htx_pkg.
module htx_mac #(
    parameter int FRAC_BITS = htx_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              issue,
    input  logic signed [htx_pkg::OPND_W-1:0] a,
    input  logic signed [htx_pkg::OPND_W-1:0] b,
    input  htx_pkg::mode_t                    mode,
    output logic signed [htx_pkg::VAL_W-1:0]  val
);
    import htx_pkg::*;

    localparam logic signed [PROD_W-1:0] QRND = PROD_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [VAL_W-1:0]  SRND = VAL_W'(1) << (29 - FRAC_BITS);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [OPND_W-1:0] a_reg;
    mode_t                    mode_reg;
    logic signed [PROD_W-1:0] qsum;
    logic signed [VAL_W-1:0]  rsum;

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            prod_reg <= a * b;
            a_reg    <= a;
            mode_reg <= mode;
        end
    end

    always_comb
    begin
        qsum = prod_reg + QRND;
        rsum = VAL_W'(a_reg) + SRND;
        case (mode_reg)
            M_QMUL:  val = VAL_W'(sat32(qsum >>> FRAC_BITS));
            M_Q30:   val = VAL_W'(prod_reg >>> Q30_SH);
            M_RAW:   val = VAL_W'(sat32(prod_reg));
            M_ROUND: val = rsum >>> (Q30_SH - FRAC_BITS);
            default: val = '0;
        endcase
    end

endmodule

### sim/tb_top.sv
// Testbench for hierarchical_2d_transform: a self-checking run with a built-in predictor.
// Depends on htx_pkg and the RTL. Words are driven from a queue; results are checked in order.
`timescale 1ns / 100ps

module tb_top;
    import htx_pkg::*;

    localparam int SLOTS    = 1024;
    localparam int FRAC     = 16;
    localparam int DRAIN_CY = 150;

    // sender/receiver idling modes
    localparam int IDLE_NONE = 0;
    localparam int IDLE_SEND = 1;
    localparam int IDLE_RECV = 2;
    localparam int IDLE_BOTH = 3;

    // APB register addresses
    localparam logic [2:0] ADDR_VP_W = 3'd0;
    localparam logic [2:0] ADDR_VP_H = 3'd4;

    typedef struct {
        logic [9:0]         idx;
        logic               hp;
        logic [9:0]         pidx;
        logic signed [31:0] sx, sy, pvx, pvy;
        logic [15:0]        rot;
        logic signed [31:0] posx, posy, anx, any;
    } entity_word_t;

    typedef struct {
        logic [9:0]         idx;
        logic signed [31:0] m [6];
    } world_mat_t;

    logic clk, rst_n;
    logic psel, penable, pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;
    logic item_valid, item_stall;
    logic [9:0] entity_index, parent_index;
    logic has_parent;
    logic signed [31:0] scale_x, scale_y, pivot_x, pivot_y;
    logic [15:0] rotation;
    logic signed [31:0] pos_x, pos_y, anchor_x, anchor_y;
    logic result_valid, result_stall;
    logic [9:0] out_index;
    logic signed [31:0] m11, m12, m21, m22, m31, m32;

    hierarchical_2d_transform dut (.*);

    // predictor state: viewport and per-slot to-child matrix and scale
    longint vp_w, vp_h;
    longint tochild_mem [SLOTS][6];
    longint scale_mem [SLOTS][2];

    entity_word_t pending_words [$];
    world_mat_t   expected_mats [$];
    entity_word_t cur_word;
    bit           written [SLOTS];
    int           written_list [$];
    bit           word_taken;
    int           idle_mode;
    int           hold_left;
    int           errors, matched, roots, children;

    function automatic longint sat(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // rounded Q16.16 product, saturated
    function automatic longint qmul(longint a, longint b);
        return sat((a * b + (64'sd1 <<< (FRAC - 1))) >>> FRAC);
    endfunction

    // polynomial sine on a binary angle, Q30 internally
    function automatic longint qsin(int unsigned ang);
        int unsigned a, q;
        longint u, x, x2, inner, mid, s, v;
        a = ang & 32'hFFFF;
        q = a >> 14;
        u = a & 32'h3FFF;
        if (q[0]) u = 16384 - u;
        x = u <<< 16;
        x2 = (x * x) >>> 30;
        inner = 64'sd688904866 - ((64'sd76016977 * x2) >>> 30);
        mid = 64'sd1686629713 - ((x2 * inner) >>> 30);
        s = (x * mid) >>> 30;
        v = (s + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
        return q[1] ? -v : v;
    endfunction

    // r = a * p, row-vector affine
    function automatic void chain(input longint a [6], input longint p [6],
                                  output longint r [6]);
        r[0] = sat(qmul(a[0], p[0]) + qmul(a[1], p[2]));
        r[1] = sat(qmul(a[0], p[1]) + qmul(a[1], p[3]));
        r[2] = sat(qmul(a[2], p[0]) + qmul(a[3], p[2]));
        r[3] = sat(qmul(a[2], p[1]) + qmul(a[3], p[3]));
        r[4] = sat(qmul(a[4], p[0]) + qmul(a[5], p[2]) + p[4]);
        r[5] = sat(qmul(a[4], p[1]) + qmul(a[5], p[3]) + p[5]);
    endfunction

    // world matrix of one entity; updates the slot's stored matrix and scale
    function automatic world_mat_t world_of(entity_word_t w);
        longint half, one, s, c, ns, ox, oy, px, py;
        longint lm [6], own [6], wm [6], tc [6], par [6];
        world_mat_t r;
        half = 64'sd1 <<< (FRAC - 1);
        one = 64'sd1 <<< FRAC;
        s = qsin(w.rot);
        c = qsin(w.rot + 16384);
        ns = -s;
        if (w.hp)
        begin
            for (int i = 0; i < 6; i++) par[i] = tochild_mem[w.pidx][i];
            ox = sat(longint'(w.posx) + qmul(sat(longint'(w.anx) - half), scale_mem[w.pidx][0]));
            oy = sat(-longint'(w.posy) + qmul(sat(half - longint'(w.any)), scale_mem[w.pidx][1]));
        end
        else
        begin
            ox = sat(longint'(w.posx) + sat((longint'(w.anx) - half) * vp_w));
            oy = sat(-longint'(w.posy) + sat((half - longint'(w.any)) * vp_h));
        end
        px = qmul(sat(one - 2 * longint'(w.pvx)), w.sx);
        py = qmul(sat(2 * longint'(w.pvy) - one), w.sy);
        lm[0] = qmul(w.sx, c);
        lm[1] = qmul(w.sx, s);
        lm[2] = qmul(w.sy, ns);
        lm[3] = qmul(w.sy, c);
        lm[4] = sat(qmul(px, c) + qmul(py, ns) + ox);
        lm[5] = sat(qmul(px, s) + qmul(py, c) + oy);
        own = '{c, s, ns, c, ox, oy};
        if (w.hp)
        begin
            chain(lm, par, wm);
            chain(own, par, tc);
        end
        else
        begin
            wm = lm;
            tc = own;
        end
        for (int i = 0; i < 6; i++) tochild_mem[w.idx][i] = tc[i];
        scale_mem[w.idx][0] = w.sx;
        scale_mem[w.idx][1] = w.sy;
        r.idx = w.idx;
        for (int i = 0; i < 6; i++) r.m[i] = wm[i][31:0];
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Driver: presents the next pending word at the falling edge once
    // the previous one was taken. Valid is held until accepted.
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (!item_valid || word_taken))
        begin
            if (pending_words.size() > 0 &&
                !((idle_mode == IDLE_SEND && $urandom_range(0, 99) < 72) ||
                  (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 14)))
            begin
                cur_word = pending_words.pop_front();
                item_valid   <= 1'b1;
                entity_index <= cur_word.idx;
                has_parent   <= cur_word.hp;
                parent_index <= cur_word.pidx;
                scale_x      <= cur_word.sx;
                scale_y      <= cur_word.sy;
                pivot_x      <= cur_word.pvx;
                pivot_y      <= cur_word.pvy;
                rotation     <= cur_word.rot;
                pos_x        <= cur_word.posx;
                pos_y        <= cur_word.posy;
                anchor_x     <= cur_word.anx;
                anchor_y     <= cur_word.any;
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // Receiver stall: a long hold-off has priority over random stalling.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            result_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (idle_mode == IDLE_RECV)
            result_stall <= ($urandom_range(0, 99) < 72);
        else if (idle_mode == IDLE_BOTH)
            result_stall <= ($urandom_range(0, 99) < 14);
        else
            result_stall <= 1'b0;
    end

    // Input acceptance: predict in acceptance order so parent state matches.
    always @(posedge clk)
    begin
        word_taken = item_valid && !item_stall;
        if (word_taken)
        begin
            expected_mats = {expected_mats, world_of(cur_word)};
            if (cur_word.hp) children++;
            else roots++;
        end
    end

    // Monitor: compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        if (result_valid && !result_stall)
        begin
            if (expected_mats.size() == 0)
            begin
                $display("%0t: unexpected result, index %0d", $time, out_index);
                errors++;
            end
            else
            begin
                world_mat_t e;
                logic signed [31:0] got [6];
                e = expected_mats.pop_front();
                got = '{m11, m12, m21, m22, m31, m32};
                if (out_index !== e.idx)
                begin
                    $display("%0t: out_index expected %0d actual %0d", $time, e.idx, out_index);
                    errors++;
                end
                for (int i = 0; i < 6; i++)
                begin
                    if (got[i] !== e.m[i])
                    begin
                        $display("%0t: slot %0d matrix word %0d expected %h actual %h",
                                 $time, e.idx, i, e.m[i], got[i]);
                        errors++;
                    end
                end
                matched++;
            end
        end
    end

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (addr == ADDR_VP_W) vp_w = data[15:0];
        else vp_h = data[15:0];
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic signed [31:0] rand_range(int span);
        return $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    // random word; mostly sane hierarchies, some full-range noise
    function automatic entity_word_t rand_word();
        entity_word_t w;
        bit wild;
        wild = ($urandom_range(0, 99) < 20);
        w.idx = $urandom_range(0, SLOTS - 1);
        w.hp = (written_list.size() > 0) && ($urandom_range(0, 99) < 65);
        w.pidx = w.hp ? 10'(written_list[$urandom_range(0, written_list.size() - 1)])
                      : 10'($urandom);
        w.sx   = (wild && $urandom_range(0, 1)) ? $urandom : rand_range(4 << 16);
        w.sy   = (wild && $urandom_range(0, 1)) ? $urandom : rand_range(4 << 16);
        w.pvx  = (wild && $urandom_range(0, 1)) ? $urandom : $urandom_range(0, 1 << 16);
        w.pvy  = (wild && $urandom_range(0, 1)) ? $urandom : $urandom_range(0, 1 << 16);
        w.rot  = $urandom;
        w.posx = (wild && $urandom_range(0, 1)) ? $urandom : rand_range(2000 << 16);
        w.posy = (wild && $urandom_range(0, 1)) ? $urandom : rand_range(2000 << 16);
        w.anx  = (wild && $urandom_range(0, 1)) ? $urandom : $urandom_range(0, 1 << 16);
        w.any  = (wild && $urandom_range(0, 1)) ? $urandom : $urandom_range(0, 1 << 16);
        return w;
    endfunction

    task automatic queue_word(entity_word_t w);
        pending_words = {pending_words, w};
        if (!written[w.idx])
        begin
            written[w.idx] = 1'b1;
            written_list = {written_list, int'(w.idx)};
        end
    endtask

    // Wait for all words taken and all results back, then let the block settle.
    task automatic drain();
        while (pending_words.size() > 0 || expected_mats.size() > 0) @(posedge clk);
        repeat (DRAIN_CY) @(posedge clk);
    endtask

    task automatic random_phase(int n, int mode, bit long_hold);
        idle_mode = mode;
        for (int i = 0; i < n; i++) queue_word(rand_word());
        // receiver holds off while the sender keeps offering words
        if (long_hold) hold_left = 600;
        drain();
    endtask

    initial
    begin
        entity_word_t w;
        int rots [8];
        rots = '{0, 16384, 32768, 49152, 65535, 8192, 1, 40000};
        errors = 0; matched = 0; roots = 0; children = 0;
        idle_mode = IDLE_NONE;
        hold_left = 0;
        vp_w = 1920;
        vp_h = 1080;
        word_taken = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        item_valid = 1'b0; result_stall = 1'b0;
        entity_index = '0; has_parent = 1'b0; parent_index = '0;
        scale_x = '0; scale_y = '0; pivot_x = '0; pivot_y = '0; rotation = '0;
        pos_x = '0; pos_y = '0; anchor_x = '0; anchor_y = '0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: roots at each quadrant boundary and at in-between angles, with default viewport
        for (int i = 0; i < 8; i++)
        begin
            w = '{idx: 10'(i), hp: 1'b0, pidx: 10'd1023, sx: 32'sh0001_0000,
                  sy: 32'sh0002_0000, pvx: 32'sh0000_8000, pvy: 32'sh0000_8000,
                  rot: 16'(rots[i]), posx: 32'sh0010_0000, posy: -32'sh0008_0000,
                  anx: 32'sh0000_4000, any: 32'sh0000_C000};
            queue_word(w);
        end
        // field extremes, saturation everywhere; slots 1023 and 1022
        w = '{idx: 10'd1023, hp: 1'b0, pidx: 10'd0, sx: 32'sh7FFF_FFFF,
              sy: 32'sh8000_0000, pvx: 32'sh8000_0000, pvy: 32'sh7FFF_FFFF,
              rot: 16'hFFFF, posx: 32'sh7FFF_FFFF, posy: 32'sh8000_0000,
              anx: 32'sh7FFF_FFFF, any: 32'sh8000_0000};
        queue_word(w);
        w.sx = 32'sh8000_0000; w.sy = 32'sh7FFF_FFFF; w.pvx = 32'sh7FFF_FFFF;
        w.pvy = 32'sh8000_0000; w.anx = 32'sh8000_0000; w.any = 32'sh7FFF_FFFF;
        w.posx = 32'sh8000_0000; w.posy = 32'sh7FFF_FFFF; w.idx = 10'd1022;
        queue_word(w);
        // chain of children, then parents equal to self and a child of an extreme root
        for (int i = 0; i < 6; i++)
        begin
            w = '{idx: 10'(20 + i), hp: 1'b1, pidx: 10'(i == 0 ? 1 : 19 + i),
                  sx: 32'sh0001_8000, sy: 32'sh0000_C000, pvx: 32'sh0000_0000,
                  pvy: 32'sh0001_0000, rot: 16'(i * 5000), posx: 32'sh0003_0000,
                  posy: 32'sh0001_0000, anx: 32'sh0001_0000, any: 32'sh0000_0000};
            queue_word(w);
        end
        w.idx = 10'd25; w.pidx = 10'd25; queue_word(w);
        w.idx = 10'd1023; w.pidx = 10'd1023; w.sx = 32'sh8000_0000; queue_word(w);
        w.idx = 10'd30; w.pidx = 10'd1022; w.sx = 32'sh7FFF_FFFF; queue_word(w);
        drain();

        // Random phases over viewport settings including extremes and zero
        apb_write(ADDR_VP_W, 32'd1);
        apb_write(ADDR_VP_H, 32'd65535);
        random_phase(150, IDLE_NONE, 1'b1);
        apb_write(ADDR_VP_W, 32'd65535);
        apb_write(ADDR_VP_H, 32'd1);
        random_phase(150, IDLE_SEND, 1'b0);
        apb_write(ADDR_VP_W, 32'd0);
        apb_write(ADDR_VP_H, 32'd0);
        random_phase(150, IDLE_RECV, 1'b0);
        apb_write(ADDR_VP_W, 32'd1920);
        apb_write(ADDR_VP_H, 32'd1080);
        random_phase(150, IDLE_BOTH, 1'b1);
        apb_write(ADDR_VP_W, $urandom);
        apb_write(ADDR_VP_H, $urandom);
        random_phase(150, IDLE_RECV, 1'b0);
        apb_write(ADDR_VP_W, 32'd65535);
        apb_write(ADDR_VP_H, 32'd65535);
        random_phase(130, IDLE_NONE, 1'b0);

        $display("Covered %0d root and %0d child entities over six viewport settings,",
                 roots, children);
        $display("%0d world matrices checked with sender gaps and receiver stalls.", matched);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #8ms;
        $display("Timeout with %0d results outstanding", expected_mats.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
